// ===== hdl/es2d_pkg.sv =====
// package for the epoch seconds to date unit
// holds widths, calendar constants, month table, fsm state, control structs and a month length function
// no dependencies
package es2d_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned YearW  = 12;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;   // day of year, below 366
  localparam int unsigned C100W  = 7;
  localparam int unsigned C400W  = 9;

  // day-of-year divide: 86400 = 675 << 7, so shift first, then multiply by
  // the reciprocal of 675; exact for every remainder below one leap year
  localparam int unsigned DayShift      = 7;
  localparam int unsigned DivInW        = 18;  // year remainder >> 7 fits 18 bits
  localparam int unsigned DayRecipW     = 19;
  localparam int unsigned DayRecipShift = 28;
  localparam int unsigned DivProdW      = DivInW + DayRecipW;
  localparam logic [DayRecipW-1:0] DayRecip = DayRecipW'(397683);  // ceil(2^28 / 675)

  localparam int unsigned SecsPerDayI  = 86400;
  localparam int unsigned FirstYearI   = 1970;

  localparam logic [EpochW-1:0] SecsPerCommonYear = EpochW'(31536000);
  localparam logic [EpochW-1:0] SecsPerLeapYear   = EpochW'(31536000 + SecsPerDayI);

  localparam logic [YearW-1:0]  FirstYear   = YearW'(FirstYearI);
  localparam logic [C100W-1:0]  FirstC100   = C100W'(FirstYearI % 100);
  localparam logic [C400W-1:0]  FirstC400   = C400W'(FirstYearI % 400);
  localparam logic [C100W-1:0]  C100Last    = C100W'(99);
  localparam logic [C400W-1:0]  C400Last    = C400W'(399);

  localparam logic [MonthW-1:0] MonthJan = MonthW'(0);
  localparam logic [MonthW-1:0] MonthFeb = MonthW'(1);
  localparam logic [MonthW-1:0] MonthDec = MonthW'(11);

  localparam logic [DayW-1:0] MonthDays [12] = '{
    DayW'(31), DayW'(28), DayW'(31), DayW'(30), DayW'(31), DayW'(30),
    DayW'(31), DayW'(31), DayW'(30), DayW'(31), DayW'(30), DayW'(31)
  };
  localparam logic [DayW-1:0] FebLeapDays = DayW'(29);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DIV,
    ST_MONTH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic ld;        // capture input, restart walk
    logic yr_step;   // subtract one year when it fits
    logic div_step;  // day of year by reciprocal multiply
    logic mon_step;  // subtract one month when not done
    logic out_ld;    // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic yr_done;
    logic mon_done;
  } dp_sts_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    if (m == MonthFeb && leap) begin
      len = FebLeapDays;
    end else if (m > MonthDec) begin
      len = MonthDays[MonthDec];
    end else begin
      len = MonthDays[m];
    end
    return len;
  endfunction

endpackage

// ===== hdl/es2d_in_if.sv =====
// input channel interface: valid/ready plus the epoch seconds payload
// depends on es2d_pkg
interface es2d_in_if import es2d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== hdl/es2d_out_if.sv =====
// output channel interface: valid/ready plus the calendar date payload
// depends on es2d_pkg
interface es2d_out_if import es2d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;
  logic [DayW-1:0]   day_of_month;

  modport source (output valid, output year, output month, output day_of_month,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  output ready);
endinterface

// ===== hdl/es2d_ctrl.sv =====
// controller fsm: sequences year walk, day divide and month walk
// depends on es2d_pkg
module es2d_ctrl import es2d_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld = 1'b1;
          state_d  = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd_o.yr_step = 1'b1;
        if (sts_i.yr_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_MONTH;
      end
      ST_MONTH: begin
        cmd_o.mon_step = 1'b1;
        if (sts_i.mon_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/es2d_dp.sv =====
// datapath: remaining seconds, year and leap counters, day divide, month walk,
// result register; depends on es2d_pkg
module es2d_dp import es2d_pkg::*; (
  input  logic              clk_i,
  input  logic [EpochW-1:0] epoch_seconds_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic [YearW-1:0]  year_o,
  output logic [MonthW-1:0] month_o,
  output logic [DayW-1:0]   day_of_month_o
);

  logic [EpochW-1:0]  rem_q;
  logic [YearW-1:0]   year_q;
  logic [C100W-1:0]   c100_q;
  logic [C400W-1:0]   c400_q;
  logic [DoyW-1:0]    doy_q;
  logic [MonthW-1:0]  mon_q;

  logic                leap;
  logic [EpochW-1:0]   yr_len;
  logic                yr_fits;
  logic [DivProdW-1:0] div_prod;
  logic [DayW-1:0]     mlen;
  logic                mon_fits;

  // full gregorian rule via running mod 100 / mod 400 counters
  assign leap    = ((year_q[1:0] == 2'b00) && (c100_q != '0)) || (c400_q == '0);
  assign yr_len  = leap ? SecsPerLeapYear : SecsPerCommonYear;
  assign yr_fits = rem_q >= yr_len;

  // remainder is below one leap year, so bits above the slice are zero
  assign div_prod = DivProdW'(rem_q[DayShift +: DivInW]) * DivProdW'(DayRecip);

  assign mlen     = month_len(mon_q, leap);
  assign mon_fits = doy_q >= DoyW'(mlen);

  assign sts_o.yr_done  = !yr_fits;
  assign sts_o.mon_done = (mon_q == MonthDec) || !mon_fits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      rem_q  <= epoch_seconds_i;
      year_q <= FirstYear;
      c100_q <= FirstC100;
      c400_q <= FirstC400;
      doy_q  <= '0;
      mon_q  <= MonthJan;
    end else if (cmd_i.yr_step && yr_fits) begin
      rem_q  <= rem_q - yr_len;
      year_q <= year_q + YearW'(1);
      c100_q <= (c100_q == C100Last) ? '0 : c100_q + C100W'(1);
      c400_q <= (c400_q == C400Last) ? '0 : c400_q + C400W'(1);
    end else if (cmd_i.div_step) begin
      doy_q <= div_prod[DayRecipShift +: DoyW];
    end else if (cmd_i.mon_step && !sts_o.mon_done) begin
      doy_q <= doy_q - DoyW'(mlen);
      mon_q <= mon_q + MonthW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      year_o         <= year_q;
      month_o        <= mon_q + MonthW'(1);
      day_of_month_o <= doy_q[DayW-1:0] + DayW'(1);
    end
  end

endmodule

// ===== hdl/epoch_seconds_to_date_unit.sv =====
// top level of the epoch seconds to date converter
// depends on es2d_pkg, es2d_in_if, es2d_out_if, es2d_ctrl, es2d_dp
//
//  channel | dir | handshake     | payload
//  in_i    | in  | valid / ready | epoch_seconds[31:0]
//  out_o   | out | valid / ready | year[11:0], month[3:0], day_of_month[4:0]
//
// a transaction loads the input, walks the years past 1970 (up to 136),
//   divides out the day of year, walks the months, loads the result
// the year-by-year walk is the long pole; one year is tested per cycle
// the day of year comes from a shift and one reciprocal multiply
// async active-low reset returns the fsm to idle and drops out valid
// a finished result sits in the output register; the next input is taken
//   while it waits, and only the final load stalls on a full output
module epoch_seconds_to_date_unit import es2d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  es2d_in_if.sink    in_i,
  es2d_out_if.source out_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // fsm owns the handshakes and issues at most one command per cycle
  es2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath holds the working registers and the result register
  es2d_dp u_dp (
    .clk_i           (clk_i),
    .epoch_seconds_i (in_i.epoch_seconds),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .year_o          (out_o.year),
    .month_o         (out_o.month),
    .day_of_month_o  (out_o.day_of_month)
  );

endmodule

// ===== hdl/es2d_chk.sv =====
// port-level checker for the epoch seconds to date unit, bound to the top
// depends on es2d_pkg
module es2d_chk import es2d_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [YearW-1:0]  year_i,
  input logic [MonthW-1:0] month_i,
  input logic [DayW-1:0]   day_of_month_i
);

  // the unit is busy for a while after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after a transaction");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(year_i) &&
      $stable(month_i) && $stable(day_of_month_i)))
    else $error("result changed while stalled");

  // year window reachable from a 32-bit timestamp
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (year_i >= FirstYear && year_i <= YearW'(2106)))
    else $error("year out of range");

  // month within 1 to 12, day at least 1, february never past 29
  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (month_i >= MonthW'(1) && month_i <= MonthW'(12) &&
      day_of_month_i >= DayW'(1) &&
      (month_i != MonthW'(2) || day_of_month_i <= FebLeapDays)))
    else $error("month or day out of range");

endmodule

bind epoch_seconds_to_date_unit es2d_chk u_es2d_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .year_i         (out_o.year),
  .month_i        (out_o.month),
  .day_of_month_i (out_o.day_of_month)
);
